### hw/rtl/bile_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bile_pkg
// Shared opcodes, status codes and cell command type for the indexed list.
// ----------------------------------------------------------------------------
package bile_pkg;

   // request opcodes
   localparam logic [2:0] OP_APPEND   = 3'd0;
   localparam logic [2:0] OP_READ     = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_INSERT   = 3'd3;
   localparam logic [2:0] OP_POP_LAST = 3'd4;
   localparam logic [2:0] OP_POP_AT   = 3'd5;
   localparam logic [2:0] OP_REMOVE   = 3'd6;
   localparam logic [2:0] OP_REVERSE  = 3'd7;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OOB       = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // field widths fixed by the interface
   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // command broadcast to every storage cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

endpackage : bile_pkg
`default_nettype wire

### hw/rtl/bile_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bile_cell
// One storage cell of the list: holds a value, shifts to and from its
// neighbors, taps out on a read match and links the first-match search chain.
// ----------------------------------------------------------------------------
module bile_cell
   import bile_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int IW         = 4,
   parameter int CW         = 5,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire cell_op_type           cmd,
   input  wire logic [IW-1:0]         q,
   input  wire logic [DATA_WIDTH-1:0] wdata,
   input  wire logic [DATA_WIDTH-1:0] lower_value,
   input  wire logic [DATA_WIDTH-1:0] upper_value,
   input  wire logic [DATA_WIDTH-1:0] key,
   input  wire logic [CW-1:0]         count,
   input  wire logic                  rev,
   input  wire logic [IW-1:0]         rd_idx,
   input  wire logic                  lo_in,
   input  wire logic                  hi_in,
   output logic [DATA_WIDTH-1:0]      value,
   output logic [DATA_WIDTH-1:0]      tap,
   output logic                       lo_out,
   output logic                       hi_out,
   output logic                       first
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  hit;

   always_comb begin
      value_in = value_ff;
      case (cmd)
         CELL_WRITE: begin
            if (MY_IDX == q) value_in = wdata;
         end
         CELL_INSERT: begin
            if (MY_IDX > q) value_in = lower_value;
            else if (MY_IDX == q) value_in = wdata;
         end
         CELL_DELETE: begin
            if (MY_IDX >= q) value_in = upper_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // only live entries take part in the search
   assign hit    = (value_ff == key) && (MY_CNT < count);
   assign lo_out = lo_in | hit;
   assign hi_out = hi_in | hit;
   // first in logical order: lowest cell, or highest cell when reversed
   assign first  = hit && (rev ? !hi_in : !lo_in);

   assign value = value_ff;
   assign tap   = (rd_idx == MY_IDX) ? value_ff : '0;

endmodule : bile_cell
`default_nettype wire

### hw/rtl/bounded_indexed_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_indexed_list_engine
// Ordered list of up to DEPTH values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_op, req_position, req_operand_value) is taken when
//   req_valid is high and req_stall is low. Each request gives exactly one
//   response (rsp_result_value, rsp_status, rsp_entry_count), handed over
//   when rsp_valid is high and rsp_stall is low.
//   Timing: the cycle after a request is taken, the cells compare and the
//   target cell is resolved; then, in the apply step, all cells shift or
//   load at once and the response is loaded into the output register. A
//   new request is taken in that apply step, so a request is not taken
//   while the one before it is still being evaluated: the evaluate/apply
//   pair over the cell row is not overlapped, since every request must see
//   the cells left by the one before it.
//   Stall: if a response is still waiting in the output register, the
//   apply step waits and req_stall stays high until it drains.
//   Reset: the list is empty and in natural order; the cells themselves are
//   not cleared since no entry is read before it is written.
// ----------------------------------------------------------------------------
module bounded_indexed_list_engine
   import bile_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [OP_W-1:0]            req_op,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic signed [VALUE_W-1:0]  req_operand_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]       rsp_result_value,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [COUNT_W-1:0]              rsp_entry_count
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_APPLY
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         count_ff;
   logic                  rev_ff;

   logic [OP_W-1:0]       op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] key_ff;

   cell_op_type           cmd_ff;
   cell_op_type           cmd_in;
   logic [IW-1:0]         q_ff;
   logic [IW-1:0]         q_in;
   logic [DATA_WIDTH-1:0] res_ff;
   logic [DATA_WIDTH-1:0] res_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [CW-1:0]         cnt_new_ff;
   logic [CW-1:0]         cnt_new_in;
   logic                  flip_ff;
   logic                  flip_in;

   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_result_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  go;
   logic                  req_take;
   cell_op_type           apply_cmd;

   logic [CMPW-1:0]       pos_x;
   logic [CMPW-1:0]       cnt_x;
   logic                  full;
   logic                  empty;
   logic                  pos_lt_cnt;
   logic                  pos_le_cnt;
   logic [IW-1:0]         cell_pos;
   logic [IW-1:0]         last_cell;
   logic [IW-1:0]         ins_cell;
   logic [IW-1:0]         rd_idx;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [IW-1:0]         found_idx;
   logic                  found;

   logic [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic [DATA_WIDTH-1:0] cell_tap   [DEPTH];
   logic [DEPTH:0]        lo_link;
   logic [DEPTH:0]        hi_link;
   logic [DEPTH-1:0]      first_vec;

   // ---------------------------------------------------------------- cells
   assign lo_link[0]     = 1'b0;
   assign hi_link[DEPTH] = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_v;
      logic [DATA_WIDTH-1:0] upper_v;

      if (k == 0) begin : g_lo_end
         assign lower_v = '0;
      end else begin : g_lo_mid
         assign lower_v = cell_value[k-1];
      end
      if (k == DEPTH - 1) begin : g_hi_end
         assign upper_v = '0;
      end else begin : g_hi_mid
         assign upper_v = cell_value[k+1];
      end

      bile_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IW         (IW),
         .CW         (CW),
         .INDEX      (k)
      ) u_cell (
         .clock       (clock),
         .cmd         (apply_cmd),
         .q           (q_ff),
         .wdata       (key_ff),
         .lower_value (lower_v),
         .upper_value (upper_v),
         .key         (key_ff),
         .count       (count_ff),
         .rev         (rev_ff),
         .rd_idx      (rd_idx),
         .lo_in       (lo_link[k]),
         .hi_in       (hi_link[k+1]),
         .value       (cell_value[k]),
         .tap         (cell_tap[k]),
         .lo_out      (lo_link[k+1]),
         .hi_out      (hi_link[k]),
         .first       (first_vec[k])
      );
   end

   always_comb begin
      rd_data   = '0;
      found_idx = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_data = rd_data | cell_tap[k];
         if (first_vec[k]) found_idx = found_idx | IW'(k);
      end
   end
   assign found = |first_vec;

   // ------------------------------------------------------------- evaluate
   assign pos_x      = CMPW'(pos_ff);
   assign cnt_x      = CMPW'(count_ff);
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pos_lt_cnt = (pos_x < cnt_x);
   assign pos_le_cnt = (pos_x <= cnt_x);
   assign cell_pos   = rev_ff ? IW'(cnt_x - pos_x - 1'b1) : IW'(pos_x);
   assign last_cell  = rev_ff ? '0 : IW'(count_ff - 1'b1);
   assign ins_cell   = rev_ff ? IW'(cnt_x - pos_x) : IW'(pos_x);
   assign rd_idx     = (op_ff == OP_POP_LAST) ? last_cell : cell_pos;

   always_comb begin
      cmd_in     = CELL_HOLD;
      q_in       = rd_idx;
      res_in     = '0;
      status_in  = ST_OK;
      cnt_new_in = count_ff;
      flip_in    = 1'b0;
      unique case (op_ff)
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd_in     = CELL_INSERT;
               q_in       = rev_ff ? '0 : IW'(count_ff);
               res_in     = key_ff;
               cnt_new_in = CW'(count_ff + 1'b1);
            end
         end
         OP_READ: begin
            if (!pos_lt_cnt) status_in = ST_OOB;
            else res_in = rd_data;
         end
         OP_WRITE: begin
            if (!pos_lt_cnt) begin
               status_in = ST_OOB;
            end else begin
               cmd_in = CELL_WRITE;
               res_in = key_ff;
            end
         end
         OP_INSERT: begin
            if (!pos_le_cnt) begin
               status_in = ST_OOB;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd_in     = CELL_INSERT;
               q_in       = ins_cell;
               res_in     = key_ff;
               cnt_new_in = CW'(count_ff + 1'b1);
            end
         end
         OP_POP_LAST: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd_in     = CELL_DELETE;
               res_in     = rd_data;
               cnt_new_in = CW'(count_ff - 1'b1);
            end
         end
         OP_POP_AT: begin
            if (!pos_lt_cnt) begin
               status_in = ST_OOB;
            end else begin
               cmd_in     = CELL_DELETE;
               res_in     = rd_data;
               cnt_new_in = CW'(count_ff - 1'b1);
            end
         end
         OP_REMOVE: begin
            if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cmd_in     = CELL_DELETE;
               q_in       = found_idx;
               res_in     = key_ff;
               cnt_new_in = CW'(count_ff - 1'b1);
            end
         end
         OP_REVERSE: begin
            flip_in = 1'b1;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // ------------------------------------------------------------- control
   assign go        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_APPLY) && go));
   assign req_take  = req_valid && !req_stall;
   assign apply_cmd = ((state_ff == S_APPLY) && go) ? cmd_ff : CELL_HOLD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a response drained in the apply cycle is replaced below
         if (rsp_valid_ff && !rsp_stall && !((state_ff == S_APPLY) && go))
            rsp_valid_ff <= 1'b0;
         if (req_take) begin
            op_ff  <= req_op;
            pos_ff <= req_position;
            key_ff <= DATA_WIDTH'(req_operand_value);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) state_ff <= S_EVAL;
            end
            S_EVAL: begin
               cmd_ff     <= cmd_in;
               q_ff       <= q_in;
               res_ff     <= res_in;
               status_ff  <= status_in;
               cnt_new_ff <= cnt_new_in;
               flip_ff    <= flip_in;
               state_ff   <= S_APPLY;
            end
            S_APPLY: begin
               if (go) begin
                  count_ff      <= cnt_new_ff;
                  rev_ff        <= rev_ff ^ flip_ff;
                  rsp_valid_ff  <= 1'b1;
                  rsp_result_ff <= VALUE_W'(res_ff);
                  rsp_status_ff <= status_ff;
                  rsp_count_ff  <= COUNT_W'(cnt_new_ff);
                  state_ff      <= req_take ? S_EVAL : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = $signed(rsp_result_ff);
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // ----------------------------------------------------------- assertions
   a_take_starts_eval: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_EVAL))
      else $error("accepted request did not enter evaluation");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && go && cmd_ff == CELL_INSERT)
      |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not grow the count by one");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && go && cmd_ff == CELL_DELETE)
      |=> (count_ff == CW'($past(count_ff) - 1'b1)))
      else $error("delete did not shrink the count by one");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && status_in != ST_OK)
      |=> (res_ff == '0 && cmd_ff == CELL_HOLD && cnt_new_ff == count_ff))
      else $error("failed request changes the list or returns data");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("response raised outside the apply step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (cnt_new_ff <= CW'(DEPTH)))
      else $error("pending count exceeds list depth");

endmodule : bounded_indexed_list_engine
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the bounded indexed list engine. A shadow
// list predicts every response; a directed opening covers the empty list,
// bad positions and the value extremes, then random rounds push the list
// toward full or empty while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import bile_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 430;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
   } list_response_type;

   // shadow list: predicts each response from the accepted request stream
   class list_scoreboard;
      logic [VALUE_W-1:0] cells [LIST_DEPTH];
      int unsigned        fill;
      bit                 flipped;
      list_response_type  pending_q [$];
      int unsigned        mismatches;

      function int unsigned cell_index(int unsigned p);
         return flipped ? fill - 1 - p : p;
      endfunction

      function void place(int unsigned p, logic [VALUE_W-1:0] v);
         int unsigned q;
         q = flipped ? fill - p : p;
         for (int unsigned k = fill; k > q; k--) cells[k] = cells[k-1];
         cells[q] = v;
         fill++;
      endfunction

      function logic [VALUE_W-1:0] extract(int unsigned p);
         int unsigned        q;
         logic [VALUE_W-1:0] v;
         q = cell_index(p);
         v = cells[q];
         for (int unsigned k = q; k + 1 < fill; k++) cells[k] = cells[k+1];
         fill--;
         return v;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VALUE_W-1:0] val);
         list_response_type rsp;
         rsp = '0;
         rsp.status = ST_OK;
         case (op)
            OP_APPEND: begin
               if (fill >= LIST_DEPTH) rsp.status = ST_FULL;
               else begin
                  place(fill, val);
                  rsp.value = val;
               end
            end
            OP_READ: begin
               if (pos >= fill) rsp.status = ST_OOB;
               else rsp.value = cells[cell_index(pos)];
            end
            OP_WRITE: begin
               if (pos >= fill) rsp.status = ST_OOB;
               else begin
                  cells[cell_index(pos)] = val;
                  rsp.value = val;
               end
            end
            OP_INSERT: begin
               // bound is checked before capacity
               if (pos > fill) rsp.status = ST_OOB;
               else if (fill >= LIST_DEPTH) rsp.status = ST_FULL;
               else begin
                  place(pos, val);
                  rsp.value = val;
               end
            end
            OP_POP_LAST: begin
               if (fill == 0) rsp.status = ST_EMPTY;
               else rsp.value = extract(fill - 1);
            end
            OP_POP_AT: begin
               if (pos >= fill) rsp.status = ST_OOB;
               else rsp.value = extract(pos);
            end
            OP_REMOVE: begin
               rsp.status = ST_NOT_FOUND;
               for (int unsigned k = 0; k < fill; k++) begin
                  if (cells[cell_index(k)] == val) begin
                     rsp.value  = extract(k);
                     rsp.status = ST_OK;
                     break;
                  end
               end
            end
            OP_REVERSE: begin
               flipped = !flipped;
            end
         endcase
         rsp.count = fill[COUNT_W-1:0];
         pending_q.push_back(rsp);
      endfunction

      task report(string what);
         if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(list_response_type got);
         list_response_type want;
         if (pending_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_q.pop_front();
         if (got.value !== want.value)
            report($sformatf("value %0d, expected %0d", got.value, want.value));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.count !== want.count)
            report($sformatf("count %0d, expected %0d", got.count, want.count));
      endtask
   endclass

   logic                      clock;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op            = OP_READ;
   logic [POS_W-1:0]          req_position      = '0;
   logic signed [VALUE_W-1:0] req_operand_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_entry_count;

   list_scoreboard board = new();
   bit             steady = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    stall_roll;
   int unsigned    idle_cycles = 0;

   bounded_indexed_list_engine #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (VALUE_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // receiver back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(99);
         if (stall_roll < 60) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= (stall_roll < 92) ? $urandom_range(2) : $urandom_range(30, 5);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response({rsp_result_value, rsp_status, rsp_entry_count});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("bounded_indexed_list_engine regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   // mix of live list contents (so remove hits), a tight pool, extremes and noise
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4 && board.fill > 0)
         return board.cells[board.cell_index($urandom_range(board.fill - 1))];
      if (r < 7) return $urandom_range(7) - 4;
      if (r == 7) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] val);
      int unsigned gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_position      <= pos;
      req_operand_value <= val;
      do @(posedge clock); while (req_stall);
      board.note_request(op, pos, val);
   endtask

   task automatic directed_requests();
      // empty list corner cases first, then a short list with reversal and bad positions
      send_request(OP_REVERSE,  5'd0,  32'h0);
      send_request(OP_POP_LAST, 5'd0,  32'h0);
      send_request(OP_POP_AT,   5'd0,  32'h0);
      send_request(OP_REMOVE,   5'd0,  32'h1234_5678);
      send_request(OP_READ,     5'd0,  32'h0);
      send_request(OP_WRITE,    5'd0,  32'h5);
      send_request(OP_INSERT,   5'd1,  32'h6);
      send_request(OP_INSERT,   5'd0,  32'h0);
      send_request(OP_APPEND,   5'd0,  32'h8000_0000);
      send_request(OP_APPEND,   5'd31, 32'h7fff_ffff);
      send_request(OP_APPEND,   5'd0,  32'hffff_ffff);
      send_request(OP_READ,     5'd3,  32'h0);
      send_request(OP_WRITE,    5'd1,  32'h5555_aaaa);
      send_request(OP_READ,     5'd4,  32'h0);
      send_request(OP_REVERSE,  5'd0,  32'h0);
      send_request(OP_READ,     5'd0,  32'h0);
      send_request(OP_INSERT,   5'd4,  32'h0000_0042);
      send_request(OP_INSERT,   5'd1,  32'haaaa_5555);
      send_request(OP_POP_AT,   5'd1,  32'h0);
      send_request(OP_REMOVE,   5'd0,  32'hffff_ffff);
      send_request(OP_REMOVE,   5'd0,  32'h0bad_cafe);
      send_request(OP_POP_LAST, 5'd0,  32'h0);
      send_request(OP_POP_AT,   5'd31, 32'h0);
      send_request(OP_POP_AT,   5'd16, 32'h0);
   endtask

   // a round leans toward growth or shrinkage so full and empty both recur
   task automatic random_round(int unsigned items, int unsigned grow_pct);
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      for (int unsigned i = 0; i < items; i++) begin
         if ($urandom_range(99) < grow_pct)
            op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
         else
            op = OP_W'($urandom_range(7));
         if ($urandom_range(9) < 8) pos = POS_W'($urandom_range(board.fill));
         else pos = POS_W'($urandom_range(31));
         val = pick_value();
         send_request(op, pos, val);
      end
   endtask

   initial begin
      int unsigned issued;
      int unsigned items;
      int unsigned grow_pct;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_requests();
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         items  = $urandom_range(40, 20);
         steady = ($urandom_range(3) == 0);
         case ($urandom_range(2))
            0: grow_pct = 80;
            1: grow_pct = 15;
            default: grow_pct = 40;
         endcase
         random_round(items, grow_pct);
         issued += items;
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("bounded_indexed_list_engine regression: pass");
      else
         $display("bounded_indexed_list_engine regression: fail");
      $finish;
   end

endmodule
